>>> hw/rtl/sgec_pkg.sv
// ----------------------------------------------------------------------------
// sgec_pkg: shared definitions for the segment grid edge crossing walker
// Widths, register indexes, sequencer states and small helpers.
// ----------------------------------------------------------------------------
package sgec_pkg;

   localparam int MAX_CROSSINGS = 64;
   localparam int CNT_W         = $clog2(MAX_CROSSINGS + 1);

   localparam int COORD_W = 32;   // Q16.16 world coordinate
   localparam int ELEM_W  = 20;
   localparam int NODE_W  = 16;
   localparam int FRAC_W  = 17;   // Q0.16 with room for 1.0
   localparam int IDX_W   = 2;

   localparam int GRID_W  = 30;   // saturated grid coordinate, Q14.16
   localparam int CELL_W  = GRID_W - 16;
   localparam int U_W     = GRID_W + 1;
   localparam int DZ_W    = 32;
   localparam int MUL_A_W = 34;
   localparam int MUL_B_W = 33;
   localparam int PROD_W  = MUL_A_W + MUL_B_W;

   localparam logic [FRAC_W-1:0] ONE_Q16 = FRAC_W'(65536);

   localparam logic [IDX_W-1:0] REG_MIN_X = 2'd0;
   localparam logic [IDX_W-1:0] REG_MIN_Y = 2'd1;
   localparam logic [IDX_W-1:0] REG_INV   = 2'd2;

   localparam logic AXIS_X = 1'b0;
   localparam logic AXIS_Y = 1'b1;

   typedef enum logic [9:0] {
      ST_IDLE  = 10'b00_0000_0001,
      ST_MAP   = 10'b00_0000_0010,
      ST_SETUP = 10'b00_0000_0100,
      ST_CP1   = 10'b00_0000_1000,
      ST_CP2   = 10'b00_0001_0000,
      ST_AXIS  = 10'b00_0010_0000,
      ST_DIV   = 10'b00_0100_0000,
      ST_B1    = 10'b00_1000_0000,
      ST_THM   = 10'b01_0000_0000,
      ST_THETA = 10'b10_0000_0000
   } state_type;

endpackage

>>> hw/rtl/sgec_if.sv
// ----------------------------------------------------------------------------
// sgec_if: channel interfaces of the segment grid edge crossing walker
// Segment request, crossing response and register write channels.
// ----------------------------------------------------------------------------
interface sgec_req_if;
   logic                             valid;
   logic                             ready;
   logic [sgec_pkg::ELEM_W-1:0]       element_id;
   logic signed [sgec_pkg::COORD_W-1:0] start_x;
   logic signed [sgec_pkg::COORD_W-1:0] start_y;
   logic signed [sgec_pkg::COORD_W-1:0] end_x;
   logic signed [sgec_pkg::COORD_W-1:0] end_y;

   modport source (output valid, element_id, start_x, start_y, end_x, end_y,
                   input ready);
   modport sink (input valid, element_id, start_x, start_y, end_x, end_y,
                 output ready);
endinterface

interface sgec_rsp_if;
   logic                              valid;
   logic                              ready;
   logic                              edge_axis;
   logic signed [sgec_pkg::NODE_W-1:0] node_x;
   logic signed [sgec_pkg::NODE_W-1:0] node_y;
   logic [sgec_pkg::ELEM_W-1:0]        cut_element;
   logic [sgec_pkg::FRAC_W-1:0]        cut_theta;
   logic [sgec_pkg::FRAC_W-1:0]        seg_weight;
   logic                              truncated;
   logic                              last;

   modport source (output valid, edge_axis, node_x, node_y, cut_element, cut_theta,
                   seg_weight, truncated, last, input ready);
   modport sink (input valid, edge_axis, node_x, node_y, cut_element, cut_theta,
                 seg_weight, truncated, last, output ready);
endinterface

interface sgec_csr_if;
   logic                           valid;
   logic                           ready;
   logic [sgec_pkg::IDX_W-1:0]     index;
   logic [sgec_pkg::COORD_W-1:0]   data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

>>> hw/rtl/segment_grid_edge_crossings.sv
// ----------------------------------------------------------------------------
// segment_grid_edge_crossings: 2D segment to grid edge crossing walker
// Maps a segment into grid units and walks it cell by cell, one crossing
// result per grid edge cut.
// ----------------------------------------------------------------------------
// Usage: write domain_min_x, domain_min_y and inv_cell_size (indexes 0..2) while
// idle, then send segments. The block takes one segment at a time and drops
// ready until the walk is done. Every multiply goes through one shared 34x33
// signed multiplier, and b1 comes from a one-bit-per-cycle divider. A segment
// first has its endpoints mapped, then each crossing takes 3 multiplies for
// the cross product and theta, 17 divider iterations and bookkeeping, with
// at most MAX_CROSSINGS = 64 crossings. A segment inside one cell
// yields nothing. One output register holds a finished crossing while the walk
// computes the next; the walk stalls only if that register is still full.
// The final crossing of a segment has last set, plus truncated if the walk was
// cut off at the limit before reaching the end cell.

module segment_grid_edge_crossings (
   input  logic        clock,
   input  logic        reset,
   sgec_req_if.sink    req,
   sgec_rsp_if.source  rsp,
   sgec_csr_if.sink    csr
);

   localparam int GRID_W  = sgec_pkg::GRID_W;
   localparam int CELL_W  = sgec_pkg::CELL_W;
   localparam int U_W     = sgec_pkg::U_W;
   localparam int DZ_W    = sgec_pkg::DZ_W;
   localparam int PROD_W  = sgec_pkg::PROD_W;
   localparam int FRAC_W  = sgec_pkg::FRAC_W;
   localparam int CNT_W   = sgec_pkg::CNT_W;
   localparam int COORD_W = sgec_pkg::COORD_W;

   // configuration registers
   logic signed [COORD_W-1:0] min_x_ff, min_y_ff;
   logic [COORD_W-1:0]        inv_ff;

   // sequencer and item state
   sgec_pkg::state_type          state_ff, state_in;
   logic [2:0]                   map_idx_ff, map_idx_in;
   logic [sgec_pkg::ELEM_W-1:0]  elem_ff;
   logic signed [COORD_W-1:0]    pt_ff [4];
   logic signed [GRID_W-1:0]     g_ff [4];      // x0.x, x0.y, x1.x, x1.y
   logic signed [PROD_W-1:0]     prod_ff, cpa_ff;
   logic signed [CELL_W-1:0]     cell_ff [2];
   logic [CNT_W-1:0]             n_ff;
   logic [FRAC_W-1:0]            last_b_ff, b1_ff;
   logic                         axis_ff, neg_ff, dzero_ff, ovf_ff;
   logic [U_W-1:0]               den_ff;
   logic [DZ_W:0]                rem_ff;
   logic [FRAC_W-1:0]            q_ff;
   logic [4:0]                   dcnt_ff;

   // output register
   logic                         rsp_valid_ff;
   logic                         o_axis_ff, o_trunc_ff, o_last_ff;
   logic signed [sgec_pkg::NODE_W-1:0] o_nx_ff, o_ny_ff;
   logic [sgec_pkg::ELEM_W-1:0]  o_elem_ff;
   logic [FRAC_W-1:0]            o_theta_ff, o_b1_ff;

   // ------------------------------------------------------------------------
   // Geometry derived from the mapped endpoints
   // ------------------------------------------------------------------------
   logic signed [U_W-1:0]    u_x, u_y, u_oth;
   logic signed [CELL_W-1:0] c0_x, c0_y, c1_x, c1_y;
   logic                     off_x, off_y, canon;
   logic signed [DZ_W-1:0]   dz_x, dz_y, dz_ax;
   logic signed [CELL_W:0]   zc_x, zc_y;

   assign u_x  = U_W'(g_ff[2]) - U_W'(g_ff[0]);
   assign u_y  = U_W'(g_ff[3]) - U_W'(g_ff[1]);
   assign c0_x = g_ff[0][GRID_W-1:16];
   assign c0_y = g_ff[1][GRID_W-1:16];
   assign c1_x = g_ff[2][GRID_W-1:16];
   assign c1_y = g_ff[3][GRID_W-1:16];
   assign off_x = (c1_x >= c0_x);
   assign off_y = (c1_y >= c0_y);
   assign canon = ~u_y[U_W-1];

   // next cell corner in the walk direction, relative to the start point
   assign zc_x = (CELL_W+1)'(cell_ff[0]) + (CELL_W+1)'({1'b0, off_x});
   assign zc_y = (CELL_W+1)'(cell_ff[1]) + (CELL_W+1)'({1'b0, off_y});
   assign dz_x = DZ_W'($signed({zc_x, 16'b0})) - DZ_W'(g_ff[0]);
   assign dz_y = DZ_W'($signed({zc_y, 16'b0})) - DZ_W'(g_ff[1]);

   assign u_oth = axis_ff ? u_x : u_y;

   // crossing axis: sign of (Z - X0) x u against the walk direction
   logic cp_pos, axis_w;
   assign cp_pos = (cpa_ff >= prod_ff);
   assign axis_w = (cell_ff[1] != c1_y) &&
                   ((cell_ff[0] == c1_x) || ((cp_pos == canon) == off_x));
   assign dz_ax  = axis_w ? dz_y : dz_x;

   // ------------------------------------------------------------------------
   // Shared multiplier
   // ------------------------------------------------------------------------
   logic signed [sgec_pkg::MUL_A_W-1:0] mul_a;
   logic signed [sgec_pkg::MUL_B_W-1:0] mul_b;
   logic signed [COORD_W:0]             map_d;
   logic signed [COORD_W-1:0]           map_min;

   assign map_min = map_idx_ff[0] ? min_y_ff : min_x_ff;
   assign map_d   = (COORD_W+1)'(pt_ff[map_idx_ff[1:0]]) - (COORD_W+1)'(map_min);

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         sgec_pkg::ST_MAP: begin
            mul_a = sgec_pkg::MUL_A_W'(map_d);
            mul_b = sgec_pkg::MUL_B_W'({1'b0, inv_ff});
         end
         sgec_pkg::ST_CP1: begin
            mul_a = sgec_pkg::MUL_A_W'(dz_x);
            mul_b = sgec_pkg::MUL_B_W'(u_y);
         end
         sgec_pkg::ST_CP2: begin
            mul_a = sgec_pkg::MUL_A_W'(dz_y);
            mul_b = sgec_pkg::MUL_B_W'(u_x);
         end
         // keep b1 * u on the other axis steady while the emit waits
         sgec_pkg::ST_THM, sgec_pkg::ST_THETA: begin
            mul_a = sgec_pkg::MUL_A_W'({1'b0, b1_ff});
            mul_b = sgec_pkg::MUL_B_W'(u_oth);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // floor to grid units and saturate to the cell range
   logic signed [PROD_W-17:0] map_q;
   logic signed [GRID_W-1:0]  map_grid;
   assign map_q = prod_ff[PROD_W-1:16];
   always_comb begin
      if (map_q > (PROD_W-16)'(2**(GRID_W-1) - 1))
         map_grid = GRID_W'(2**(GRID_W-1) - 1);
      else if (map_q < -(PROD_W-16)'(2**(GRID_W-1)))
         map_grid = {1'b1, {(GRID_W-1){1'b0}}};
      else
         map_grid = map_q[GRID_W-1:0];
   end

   // ------------------------------------------------------------------------
   // Divider step, b1 clamp and theta
   // ------------------------------------------------------------------------
   logic              div_ge;
   logic [DZ_W:0]     div_r;
   assign div_ge = (rem_ff >= (DZ_W+1)'(den_ff));
   assign div_r  = div_ge ? rem_ff - (DZ_W+1)'(den_ff) : rem_ff;

   logic [FRAC_W-1:0] b1_w;
   always_comb begin
      if (dzero_ff)
         b1_w = sgec_pkg::ONE_Q16;
      else if (neg_ff)
         b1_w = last_b_ff;
      else if (ovf_ff || q_ff > sgec_pkg::ONE_Q16)
         b1_w = sgec_pkg::ONE_Q16;
      else if (q_ff < last_b_ff)
         b1_w = last_b_ff;
      else
         b1_w = q_ff;
   end

   logic signed [COORD_W+1:0] pos_w, base_w, theta_w;
   logic [FRAC_W-1:0]         theta_c;
   logic signed [CELL_W-1:0]  cell_oth;
   assign cell_oth = axis_ff ? cell_ff[0] : cell_ff[1];
   assign pos_w  = (COORD_W+2)'(axis_ff ? g_ff[0] : g_ff[1]) +
                   (COORD_W+2)'($signed(prod_ff[COORD_W+16:16]));
   assign base_w = (COORD_W+2)'($signed({cell_oth, 16'b0}));
   assign theta_w = pos_w - base_w;
   always_comb begin
      if (theta_w < 0)
         theta_c = '0;
      else if (theta_w > (COORD_W+2)'(sgec_pkg::ONE_Q16))
         theta_c = sgec_pkg::ONE_Q16;
      else
         theta_c = theta_w[FRAC_W-1:0];
   end

   // step the walk and decide whether this crossing ends it
   logic signed [CELL_W-1:0] step_cell, nx_cell_x, nx_cell_y;
   logic                     step_off, done_w, limit_w;
   logic [CNT_W-1:0]         n_next;
   assign step_off  = axis_ff ? off_y : off_x;
   assign step_cell = (axis_ff ? cell_ff[1] : cell_ff[0]) +
                      (step_off ? CELL_W'(1) : -CELL_W'(1));
   assign nx_cell_x = axis_ff ? cell_ff[0] : step_cell;
   assign nx_cell_y = axis_ff ? step_cell : cell_ff[1];
   assign done_w  = (nx_cell_x == c1_x) && (nx_cell_y == c1_y);
   assign n_next  = n_ff + CNT_W'(1);
   assign limit_w = (n_next == CNT_W'(sgec_pkg::MAX_CROSSINGS));

   logic emit_ok;
   assign emit_ok = ~rsp_valid_ff | rsp.ready;

   // ------------------------------------------------------------------------
   // Sequencer
   // ------------------------------------------------------------------------
   always_comb begin
      state_in   = state_ff;
      map_idx_in = map_idx_ff;
      case (state_ff)
         sgec_pkg::ST_IDLE: begin
            map_idx_in = '0;
            if (req.valid)
               state_in = sgec_pkg::ST_MAP;
         end
         sgec_pkg::ST_MAP: begin
            map_idx_in = map_idx_ff + 3'd1;
            if (map_idx_ff == 3'd4)
               state_in = sgec_pkg::ST_SETUP;
         end
         sgec_pkg::ST_SETUP: begin
            if (c0_x == c1_x && c0_y == c1_y)
               state_in = sgec_pkg::ST_IDLE;
            else
               state_in = sgec_pkg::ST_CP1;
         end
         sgec_pkg::ST_CP1:  state_in = sgec_pkg::ST_CP2;
         sgec_pkg::ST_CP2:  state_in = sgec_pkg::ST_AXIS;
         sgec_pkg::ST_AXIS: state_in = sgec_pkg::ST_DIV;
         sgec_pkg::ST_DIV: begin
            if (dcnt_ff == 5'd0)
               state_in = sgec_pkg::ST_B1;
         end
         sgec_pkg::ST_B1:   state_in = sgec_pkg::ST_THM;
         sgec_pkg::ST_THM:  state_in = sgec_pkg::ST_THETA;
         sgec_pkg::ST_THETA: begin
            if (emit_ok)
               state_in = (done_w || limit_w) ? sgec_pkg::ST_IDLE : sgec_pkg::ST_CP1;
         end
         default: state_in = sgec_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= sgec_pkg::ST_IDLE;
         map_idx_ff <= '0;
         min_x_ff   <= '0;
         min_y_ff   <= '0;
         inv_ff     <= COORD_W'(65536);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         map_idx_ff <= map_idx_in;
         if (csr.valid) begin
            case (csr.index)
               sgec_pkg::REG_MIN_X: min_x_ff <= csr.data;
               sgec_pkg::REG_MIN_Y: min_y_ff <= csr.data;
               sgec_pkg::REG_INV:   inv_ff   <= csr.data;
               default: ;
            endcase
         end
         if (state_ff == sgec_pkg::ST_THETA && emit_ok)
            rsp_valid_ff <= 1'b1;
         else if (rsp.ready)
            rsp_valid_ff <= 1'b0;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      case (state_ff)
         sgec_pkg::ST_IDLE: begin
            elem_ff  <= req.element_id;
            pt_ff[0] <= req.start_x;
            pt_ff[1] <= req.start_y;
            pt_ff[2] <= req.end_x;
            pt_ff[3] <= req.end_y;
         end
         sgec_pkg::ST_MAP: begin
            if (map_idx_ff != 3'd0)
               g_ff[map_idx_ff[1:0] - 2'd1] <= map_grid;
         end
         sgec_pkg::ST_SETUP: begin
            cell_ff[0] <= c0_x;
            cell_ff[1] <= c0_y;
            n_ff       <= '0;
            last_b_ff  <= '0;
         end
         sgec_pkg::ST_CP2: begin
            cpa_ff <= prod_ff;
         end
         sgec_pkg::ST_AXIS: begin
            // load the divider with |dz| / |u| on the chosen axis
            axis_ff  <= axis_w;
            den_ff   <= U_W'(axis_w ? (u_y[U_W-1] ? -u_y : u_y)
                                    : (u_x[U_W-1] ? -u_x : u_x));
            dzero_ff <= axis_w ? (u_y == '0) : (u_x == '0);
            neg_ff   <= dz_ax[DZ_W-1] ^ (axis_w ? u_y[U_W-1] : u_x[U_W-1]);
            rem_ff   <= (DZ_W+1)'(dz_ax[DZ_W-1] ? -dz_ax : dz_ax);
            ovf_ff   <= ((DZ_W+1)'(dz_ax[DZ_W-1] ? -dz_ax : dz_ax) >=
                         (DZ_W+1)'({(axis_w ? (u_y[U_W-1] ? -u_y : u_y)
                                            : (u_x[U_W-1] ? -u_x : u_x)), 1'b0}));
            q_ff     <= '0;
            dcnt_ff  <= 5'd16;
         end
         sgec_pkg::ST_DIV: begin
            q_ff    <= {q_ff[FRAC_W-2:0], div_ge};
            rem_ff  <= {div_r[DZ_W-1:0], 1'b0};
            dcnt_ff <= dcnt_ff - 5'd1;
         end
         sgec_pkg::ST_B1: begin
            b1_ff     <= b1_w;
            last_b_ff <= b1_w;
         end
         sgec_pkg::ST_THETA: begin
            if (emit_ok) begin
               o_axis_ff  <= ~axis_ff;
               o_nx_ff    <= sgec_pkg::NODE_W'(cell_ff[0]) +
                             sgec_pkg::NODE_W'({1'b0, ~axis_ff & off_x});
               o_ny_ff    <= sgec_pkg::NODE_W'(cell_ff[1]) +
                             sgec_pkg::NODE_W'({1'b0, axis_ff & off_y});
               o_elem_ff  <= elem_ff;
               o_theta_ff <= theta_c;
               o_b1_ff    <= b1_ff;
               o_last_ff  <= done_w | limit_w;
               o_trunc_ff <= ~done_w & limit_w;
               cell_ff[0] <= nx_cell_x;
               cell_ff[1] <= nx_cell_y;
               n_ff       <= n_next;
            end
         end
         default: ;
      endcase
   end

   assign req.ready       = (state_ff == sgec_pkg::ST_IDLE);
   assign csr.ready       = 1'b1;
   assign rsp.valid       = rsp_valid_ff;
   assign rsp.edge_axis   = o_axis_ff;
   assign rsp.node_x      = o_nx_ff;
   assign rsp.node_y      = o_ny_ff;
   assign rsp.cut_element = o_elem_ff;
   assign rsp.cut_theta   = o_theta_ff;
   assign rsp.seg_weight  = o_b1_ff;
   assign rsp.truncated   = o_trunc_ff;
   assign rsp.last        = o_last_ff;

endmodule
